### rtl/apsp_pkg.sv
package apsp_pkg;

  // table geometry
  localparam int unsigned MAX_VERTICES = 8;
  localparam int unsigned DIST_W       = 24;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned ADDR_W       = 2 * IDX_W;
  localparam int unsigned CELLS        = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int unsigned WEIGHT_W     = 16;
  localparam int unsigned REQ_W        = 2;

  // all-ones distance stands for "no path"
  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  typedef logic [DIST_W-1:0] dist_t;

  // request codes; the fourth code is ignored
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_ADD     = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_e;

  // addition that sticks at infinity
  function automatic dist_t sat_add(input dist_t x, input dist_t y);
    logic [DIST_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (x == DIST_INF || y == DIST_INF || s >= {1'b0, DIST_INF}) begin
      return DIST_INF;
    end
    return s[DIST_W-1:0];
  endfunction

endpackage

### rtl/all_pairs_shortest_path_top.sv
// Clear and add-edge words leave busy low; the next word may follow.
// Compute with n vertices in use: busy through the table copy of all CELLS entries,
// relaxation at one cell per cycle with a row fetch before each row, then readout.
// Results leave one per cycle, the first in the cycle after readout starts; no back-pressure.
// Reset: edge table reads as zero on the diagonal and infinity elsewhere at once (valid bits),
// vertex count 8; the distance store is not cleared.
module all_pairs_shortest_path_top
  import apsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [IDX_W-1:0]    vertex_a_i,
  input  logic [IDX_W-1:0]    vertex_b_i,
  input  logic [WEIGHT_W-1:0] edge_weight_i,
  input  logic                vertex_count_we_i,
  input  logic [CNT_W-1:0]    vertex_count_i,
  output logic                result_valid_o,
  output logic [IDX_W-1:0]    row_vertex_o,
  output logic [IDX_W-1:0]    col_vertex_o,
  output logic [DIST_W-1:0]   distance_o,
  output logic                unreachable_o,
  output logic                last_entry_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COPY = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_CELL = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  vcount_q;
  logic [CNT_W-1:0]  n_use;
  logic [IDX_W-1:0]  n_last;
  logic              accept;
  logic              add_ok;

  logic [IDX_W-1:0]  k_q, k_d, i_q, i_d, j_q, j_d;
  logic [ADDR_W-1:0] cp_cnt_q, cp_cnt_d;

  // edge table: symmetric, so only the (low, high) ordered entry is kept
  dist_t             edge_mem [CELLS];
  logic [CELLS-1:0]  edge_vld_q;
  logic [IDX_W-1:0]  e_lo, e_hi, c_lo, c_hi;
  logic [ADDR_W-1:0] e_waddr, e_raddr;
  dist_t             edge_rd_q;
  logic              edge_rv_q, cp_diag_q;

  // distance store
  dist_t             dist_mem [CELLS];
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  dist_t             rd_a_q, rd_b_q;
  logic              dst_we;
  logic [ADDR_W-1:0] dst_wa;
  dist_t             dst_wd;

  // copy write stage
  logic              cp_wv_q, cp_wv_d;
  logic [ADDR_W-1:0] cp_wa_q;

  // relaxation stage
  logic              row_ld_q, row_ld_d;
  dist_t             ik_q;
  logic              cv_q, cv_d;
  logic [ADDR_W-1:0] cw_addr_q, cw_addr_d;
  dist_t             via;
  logic              relax_we;

  // readout stage
  logic              em_v_q, em_v_d;
  logic [IDX_W-1:0]  em_row_q, em_col_q;
  logic              em_last_q, em_last_d;

  // vertices in use, clamped to the table size
  always_comb begin
    if (vcount_q > CNT_W'(MAX_VERTICES)) begin
      n_use = CNT_W'(MAX_VERTICES);
    end else begin
      n_use = vcount_q;
    end
    n_last = IDX_W'(n_use - CNT_W'(1));
  end

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign add_ok = (CNT_W'(vertex_a_i) < n_use) && (CNT_W'(vertex_b_i) < n_use);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CNT_W'(8);
    end else if (vertex_count_we_i) begin
      vcount_q <= vertex_count_i;
    end
  end

  // edge table addressing
  always_comb begin
    if (vertex_a_i < vertex_b_i) begin
      e_lo = vertex_a_i;
      e_hi = vertex_b_i;
    end else begin
      e_lo = vertex_b_i;
      e_hi = vertex_a_i;
    end
    if (cp_cnt_q[ADDR_W-1:IDX_W] < cp_cnt_q[IDX_W-1:0]) begin
      c_lo = cp_cnt_q[ADDR_W-1:IDX_W];
      c_hi = cp_cnt_q[IDX_W-1:0];
    end else begin
      c_lo = cp_cnt_q[IDX_W-1:0];
      c_hi = cp_cnt_q[ADDR_W-1:IDX_W];
    end
    e_waddr = {e_lo, e_hi};
    e_raddr = {c_lo, c_hi};
  end

  // edge table valid bits; clear request drops them all
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_vld_q <= '0;
    end else if (accept && req_type_i == REQ_CLEAR) begin
      edge_vld_q <= '0;
    end else if (accept && req_type_i == REQ_ADD && add_ok) begin
      edge_vld_q[e_waddr] <= 1'b1;
    end
  end

  // edge table memory
  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_ADD && add_ok) begin
      edge_mem[e_waddr] <= DIST_W'(edge_weight_i);
    end
    edge_rd_q <= edge_mem[e_raddr];
    edge_rv_q <= edge_vld_q[e_raddr];
    cp_diag_q <= (c_lo == c_hi);
  end

  // relaxation: via k, keep the smaller
  assign via      = sat_add(ik_q, rd_a_q);
  assign relax_we = cv_q && (via < rd_b_q);

  // distance store write port: copy and relaxation never overlap
  always_comb begin
    dst_we = 1'b0;
    dst_wa = cw_addr_q;
    dst_wd = via;
    if (cp_wv_q) begin
      dst_we = 1'b1;
      dst_wa = cp_wa_q;
      if (edge_rv_q) begin
        dst_wd = edge_rd_q;
      end else if (cp_diag_q) begin
        dst_wd = '0;
      end else begin
        dst_wd = DIST_INF;
      end
    end else if (relax_we) begin
      dst_we = 1'b1;
    end
  end

  // distance store memory, two registered read ports
  always_ff @(posedge clk_i) begin
    if (dst_we) begin
      dist_mem[dst_wa] <= dst_wd;
    end
    rd_a_q <= dist_mem[rd_a_addr];
    rd_b_q <= dist_mem[rd_b_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cp_wa_q   <= cp_cnt_q;
    cw_addr_q <= cw_addr_d;
    if (row_ld_q) begin
      ik_q <= rd_b_q;
    end
    em_row_q  <= i_q;
    em_col_q  <= j_q;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    i_d       = i_q;
    j_d       = j_q;
    cp_cnt_d  = cp_cnt_q;
    cp_wv_d   = 1'b0;
    row_ld_d  = 1'b0;
    cv_d      = 1'b0;
    em_v_d    = 1'b0;
    em_last_d = 1'b0;
    cw_addr_d = {i_q, j_q};
    rd_a_addr = {k_q, j_q};
    rd_b_addr = {i_q, j_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept && req_type_i == REQ_COMPUTE && n_use != '0) begin
          state_d  = S_COPY;
          cp_cnt_d = '0;
        end
      end
      S_COPY: begin
        cp_wv_d  = 1'b1;
        cp_cnt_d = cp_cnt_q + ADDR_W'(1);
        if (cp_cnt_q == ADDR_W'(CELLS - 1)) begin
          state_d = S_ROW;
          k_d     = '0;
          i_d     = '0;
          j_d     = '0;
        end
      end
      S_ROW: begin
        // fetch d[i][k] once per row; row and column k stay fixed over pass k
        rd_b_addr = {i_q, k_q};
        row_ld_d  = 1'b1;
        j_d       = '0;
        state_d   = S_CELL;
      end
      S_CELL: begin
        cv_d = 1'b1;
        if (j_q == n_last) begin
          j_d = '0;
          if (i_q == n_last) begin
            i_d = '0;
            if (k_q == n_last) begin
              state_d = S_EMIT;
            end else begin
              k_d     = k_q + IDX_W'(1);
              state_d = S_ROW;
            end
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_ROW;
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      S_EMIT: begin
        em_v_d = 1'b1;
        if (j_q == n_last) begin
          j_d = '0;
          if (i_q == n_last) begin
            em_last_d = 1'b1;
            i_d       = '0;
            state_d   = S_IDLE;
          end else begin
            i_d = i_q + IDX_W'(1);
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      k_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      cp_cnt_q  <= '0;
      cp_wv_q   <= 1'b0;
      row_ld_q  <= 1'b0;
      cv_q      <= 1'b0;
      em_v_q    <= 1'b0;
      em_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      i_q       <= i_d;
      j_q       <= j_d;
      cp_cnt_q  <= cp_cnt_d;
      cp_wv_q   <= cp_wv_d;
      row_ld_q  <= row_ld_d;
      cv_q      <= cv_d;
      em_v_q    <= em_v_d;
      em_last_q <= em_last_d;
    end
  end

  // result word
  assign result_valid_o = em_v_q;
  assign row_vertex_o   = em_row_q;
  assign col_vertex_o   = em_col_q;
  assign distance_o     = rd_b_q;
  assign unreachable_o  = (rd_b_q == DIST_INF);
  assign last_entry_o   = em_last_q;

`ifndef ASSERT_OFF
  // results come only out of the readout phase
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_EMIT))
    else $error("result word outside readout");

  // last marker only rides on a result word
  a_last_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_entry_o |-> result_valid_o)
    else $error("last marker without result word");

  // copy and relaxation never contend for the write port
  a_write_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cp_wv_q && cv_q))
    else $error("copy and relaxation write together");

  // an accepted compute with vertices in use raises busy
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_COMPUTE && n_use != '0) |=> busy)
    else $error("compute word did not start the sequencer");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import apsp_pkg::*;

  // fourth request code, ignored by the block
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [IDX_W-1:0]    a;
    logic [IDX_W-1:0]    b;
    logic [WEIGHT_W-1:0] weight;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    dist_t            path_len;
    logic             unreach;
    logic             last;
  } distance_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [REQ_W-1:0]    req_type_i = '0;
  logic [IDX_W-1:0]    vertex_a_i = '0;
  logic [IDX_W-1:0]    vertex_b_i = '0;
  logic [WEIGHT_W-1:0] edge_weight_i = '0;
  logic                vertex_count_we_i = 1'b0;
  logic [CNT_W-1:0]    vertex_count_i = '0;
  logic                result_valid_o;
  logic [IDX_W-1:0]    row_vertex_o;
  logic [IDX_W-1:0]    col_vertex_o;
  logic [DIST_W-1:0]   distance_o;
  logic                unreachable_o;
  logic                last_entry_o;

  all_pairs_shortest_path_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .vertex_a_i        (vertex_a_i),
    .vertex_b_i        (vertex_b_i),
    .edge_weight_i     (edge_weight_i),
    .vertex_count_we_i (vertex_count_we_i),
    .vertex_count_i    (vertex_count_i),
    .result_valid_o    (result_valid_o),
    .row_vertex_o      (row_vertex_o),
    .col_vertex_o      (col_vertex_o),
    .distance_o        (distance_o),
    .unreachable_o     (unreachable_o),
    .last_entry_o      (last_entry_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the block state
  dist_t          edge_tbl [MAX_VERTICES][MAX_VERTICES];
  int             active_vertices = MAX_VERTICES;
  request_t       pending_q [$];
  distance_word_t dist_expected_q [$];
  request_t       on_port;
  int             send_idle_pct = 0;
  int             fail_count = 0;

  function automatic void clear_edges();
    for (int r = 0; r < MAX_VERTICES; r++) begin
      for (int c = 0; c < MAX_VERTICES; c++) begin
        edge_tbl[r][c] = (r == c) ? '0 : DIST_INF;
      end
    end
  endfunction

  // path length through an intermediate vertex, stuck at infinity
  function automatic dist_t path_sum(input dist_t x, input dist_t y);
    logic [DIST_W:0] s;
    if (x == DIST_INF || y == DIST_INF) begin
      return DIST_INF;
    end
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, DIST_INF}) ? DIST_INF : s[DIST_W-1:0];
  endfunction

  // update the shadow table and queue the distance words a request produces
  function automatic void apply_request(input request_t rq);
    dist_t          d [MAX_VERTICES][MAX_VERTICES];
    dist_t          via;
    distance_word_t w;
    int             n;
    n = active_vertices;
    case (rq.req)
      REQ_CLEAR: begin
        clear_edges();
      end
      REQ_ADD: begin
        if (rq.a < n && rq.b < n) begin
          edge_tbl[rq.a][rq.b] = dist_t'(rq.weight);
          edge_tbl[rq.b][rq.a] = dist_t'(rq.weight);
        end
      end
      REQ_COMPUTE: begin
        d = edge_tbl;
        for (int k = 0; k < n; k++) begin
          for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
              via = path_sum(d[i][k], d[k][j]);
              if (via < d[i][j]) begin
                d[i][j] = via;
              end
            end
          end
        end
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            w.row      = IDX_W'(i);
            w.col      = IDX_W'(j);
            w.path_len = d[i][j];
            w.unreach  = (d[i][j] == DIST_INF);
            w.last     = (i == n - 1) && (j == n - 1);
            dist_expected_q = {dist_expected_q, w};
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // request driver: hold start until the block takes the word
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request(on_port);
      end
      if (!start || !busy) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_port       = pending_q.pop_front();
          start         <= 1'b1;
          req_type_i    <= on_port.req;
          vertex_a_i    <= on_port.a;
          vertex_b_i    <= on_port.b;
          edge_weight_i <= on_port.weight;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // distance word checker
  always @(posedge clk_i) begin : check_words
    distance_word_t got;
    distance_word_t want;
    if (rst_ni && result_valid_o) begin
      got.row      = row_vertex_o;
      got.col      = col_vertex_o;
      got.path_len = distance_o;
      got.unreach  = unreachable_o;
      got.last     = last_entry_o;
      if (dist_expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected word: row %0d col %0d dist %0h unr %0b last %0b",
                   got.row, got.col, got.path_len, got.unreach, got.last);
        end
      end else begin
        want = dist_expected_q.pop_front();
        if (got.row !== want.row || got.col !== want.col ||
            got.path_len !== want.path_len ||
            got.unreach !== want.unreach || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: exp row %0d col %0d dist %0h unr %0b last %0b",
                     want.row, want.col, want.path_len, want.unreach, want.last);
            $display("          got row %0d col %0d dist %0h unr %0b last %0b",
                     got.row, got.col, got.path_len, got.unreach, got.last);
          end
        end
      end
    end
  end

  task automatic push_req(input logic [REQ_W-1:0] req, input int a, input int b,
                          input int weight);
    request_t rq;
    rq.req    = req;
    rq.a      = IDX_W'(a);
    rq.b      = IDX_W'(b);
    rq.weight = WEIGHT_W'(weight);
    pending_q = {pending_q, rq};
  endtask

  function automatic int pick_weight();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 16'hFFFF;
      2, 3:    return $urandom_range(15);
      default: return $urandom_range(16'hFFFF);
    endcase
  endfunction

  function automatic int pick_vertex();
    return (active_vertices == 0) ? $urandom_range(MAX_VERTICES - 1)
                                  : $urandom_range(active_vertices - 1);
  endfunction

  // wait for the block to go quiet with nothing outstanding
  task automatic settle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || start || busy || dist_expected_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_count(input int v);
    @(posedge clk_i);
    vertex_count_we_i <= 1'b1;
    vertex_count_i    <= CNT_W'(v);
    @(posedge clk_i);
    vertex_count_we_i <= 1'b0;
    active_vertices = (v > MAX_VERTICES) ? MAX_VERTICES : v;
  endtask

  // mostly clear/add/compute graphs with random content, some loose words
  task automatic run_phase(input int count, input int idle_pct, input int budget);
    int queued;
    int edges;
    settle();
    write_count(count);
    send_idle_pct = idle_pct;
    queued = 0;
    while (queued < budget) begin
      if ($urandom_range(9) < 7) begin
        if ($urandom_range(3) != 0) begin
          push_req(REQ_CLEAR, $urandom_range(7), $urandom_range(7), $urandom_range(16'hFFFF));
          queued++;
        end
        edges = $urandom_range(1, 2 * active_vertices + 2);
        repeat (edges) begin
          push_req(REQ_ADD, pick_vertex(), pick_vertex(), pick_weight());
        end
        push_req(REQ_COMPUTE, $urandom_range(7), $urandom_range(7), $urandom_range(16'hFFFF));
        queued += edges + 1;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          logic [REQ_W-1:0] req;
          req = REQ_W'($urandom_range(3));
          push_req(req, $urandom_range(7), $urandom_range(7), $urandom_range(16'hFFFF));
          if (req != REQ_UNUSED) begin
            queued++;
          end
        end
      end
    end
  endtask

  initial begin
    clear_edges();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: table straight from reset, overwrites both ways and on the diagonal
    push_req(REQ_COMPUTE, 0, 0, 0);
    push_req(REQ_ADD, 0, 7, 16'hFFFF);
    push_req(REQ_ADD, 7, 0, 0);
    push_req(REQ_ADD, 3, 3, 9);
    push_req(REQ_ADD, 1, 2, 1);
    push_req(REQ_ADD, 2, 5, 2);
    push_req(REQ_ADD, 5, 6, 0);
    push_req(REQ_ADD, 4, 4, 0);
    push_req(REQ_UNUSED, 7, 7, 16'hFFFF);
    push_req(REQ_COMPUTE, 7, 7, 16'hFFFF);
    push_req(REQ_CLEAR, 5, 2, 16'h5555);
    push_req(REQ_ADD, 6, 1, 16'h5555);
    push_req(REQ_ADD, 1, 6, 16'hAAAA);
    push_req(REQ_ADD, 2, 6, 16'hFFFF);
    push_req(REQ_ADD, 1, 2, 16'hFFFF);
    push_req(REQ_COMPUTE, 2, 5, 16'hAAAA);

    // random phases over vertex counts, including zero and above table size
    run_phase(8, 0, 10);
    run_phase(3, 82, 10);
    run_phase(15, 0, 10);
    run_phase(1, 7, 8);
    run_phase(0, 0, 8);
    run_phase(5, 82, 10);
    run_phase(8, 7, 10);

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && dist_expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
